// ===== src/swap_extent_allocator_assert.svh =====
// Assertion macros for the swap extent allocator
`ifndef SWAP_EXTENT_ALLOCATOR_ASSERT_SVH
`define SWAP_EXTENT_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SEA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEA_ASSERT(lbl, prop, msg)
`define SEA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/sea_pkg.sv =====
package sea_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int PAGE_BYTES  = 4096;

  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 21;
  localparam int IDX_W      = $clog2(MAX_EXTENTS);
  localparam int CNT_W      = $clog2(MAX_EXTENTS + 1);
  localparam int PG_SH      = $clog2(PAGE_BYTES);
  localparam int PAGE_NUM_W = ADDR_W - PG_SH;
  localparam int LIM_W      = (PAGE_NUM_W + 1 > LEN_W) ? PAGE_NUM_W + 1 : LEN_W;
  localparam int END_W      = ((LEN_W + PG_SH > ADDR_W) ? LEN_W + PG_SH : ADDR_W) + 1;
  localparam int SUM_W      = LEN_W + 2;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic CFG_SWAP_BASE   = 1'b0;
  localparam logic CFG_TOTAL_PAGES = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NO_SPACE,
    STAT_DOUBLE_FREE,
    STAT_TABLE_FULL
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_SEARCH,
    ST_DECIDE,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } extent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    extent_t          wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== src/sea_extent_ram.sv =====
module sea_extent_ram (
  input  logic              clk,
  input  sea_pkg::ram_req_t req,
  output sea_pkg::extent_t  rdata
);

  sea_pkg::extent_t mem [sea_pkg::MAX_EXTENTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== src/sea_ctrl.sv =====
`include "swap_extent_allocator_assert.svh"

module sea_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sea_pkg::ADDR_W-1:0] s_tdata,
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [39:0]                m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [31:0]                cfg_data,
  output sea_pkg::ram_req_t          ram_req,
  input  sea_pkg::extent_t           rdata
);

  localparam int CW = sea_pkg::CNT_W;
  localparam int IW = sea_pkg::IDX_W;

  sea_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] w, w_next;
  logic [sea_pkg::ADDR_W-1:0] addr, addr_next;
  sea_pkg::extent_t prev, prev_next;
  sea_pkg::extent_t cur, cur_next;
  logic cur_v, cur_v_next;
  logic [sea_pkg::ADDR_W-1:0] res_granted, res_granted_next;
  sea_pkg::status_t res_status, res_status_next;
  logic reload_pend, reload_pend_next;
  logic [sea_pkg::ADDR_W-1:0] swap_base;
  logic [sea_pkg::LEN_W-1:0] total_pages;

  logic cfg_fire, s_fire, out_free;
  logic [sea_pkg::PAGE_NUM_W-1:0] base_pg;
  logic [sea_pkg::LIM_W-1:0] limit;
  logic [sea_pkg::LEN_W-1:0] pages_cl;
  logic [sea_pkg::ADDR_W-1:0] in_addr;
  logic [sea_pkg::END_W-1:0] prev_end, addr_nx, addr_ext;
  logic [sea_pkg::SUM_W-1:0] jp_sum;
  logic dup, jn, jp, pv;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s_tready  = (state == sea_pkg::ST_IDLE) && !reload_pend;
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // reload: one extent at the aligned base, clamped to end at the top of the address space
  assign base_pg = swap_base[sea_pkg::ADDR_W-1:sea_pkg::PG_SH];
  assign limit   = (sea_pkg::LIM_W'(1) << sea_pkg::PAGE_NUM_W) - sea_pkg::LIM_W'(base_pg);
  assign pages_cl = (sea_pkg::LIM_W'(total_pages) > limit) ?
                    limit[sea_pkg::LEN_W-1:0] : total_pages;

  assign in_addr = {s_tdata[sea_pkg::ADDR_W-1:sea_pkg::PG_SH], sea_pkg::PG_SH'(0)};

  assign pv       = (p != '0);
  assign prev_end = sea_pkg::END_W'(prev.start) + (sea_pkg::END_W'(prev.len) << sea_pkg::PG_SH);
  assign addr_ext = sea_pkg::END_W'(addr);
  assign addr_nx  = addr_ext + sea_pkg::END_W'(sea_pkg::PAGE_BYTES);
  assign dup = (cur_v && (cur.start == addr)) || (pv && (prev_end > addr_ext));
  assign jn  = cur_v && (sea_pkg::END_W'(cur.start) == addr_nx) && (cur.len != sea_pkg::LEN_MAX);
  assign jp_sum = sea_pkg::SUM_W'(prev.len) + sea_pkg::SUM_W'(1) +
                  (jn ? sea_pkg::SUM_W'(cur.len) : '0);
  assign jp  = pv && (prev_end == addr_ext) && (jp_sum <= sea_pkg::SUM_W'(sea_pkg::LEN_MAX));

  always_comb begin
    state_next       = state;
    count_next       = count;
    ptr_next         = ptr;
    p_next           = p;
    w_next           = w;
    addr_next        = addr;
    prev_next        = prev;
    cur_next         = cur;
    cur_v_next       = cur_v;
    res_granted_next = res_granted;
    res_status_next  = res_status;
    reload_pend_next = reload_pend || cfg_fire;
    ram_req          = '0;

    case (state)
      sea_pkg::ST_IDLE: begin
        if (reload_pend) begin
          ram_req.we       = 1'b1;
          ram_req.waddr    = '0;
          ram_req.wdata    = '{start: {base_pg, sea_pkg::PG_SH'(0)}, len: pages_cl};
          count_next       = (pages_cl == '0) ? '0 : CW'(1);
          ptr_next         = '0;
          reload_pend_next = cfg_fire;
        end else if (s_fire) begin
          res_granted_next = '0;
          res_status_next  = sea_pkg::STAT_OK;
          if (s_tuser == sea_pkg::KIND_ALLOC) begin
            if (count == '0) begin
              res_status_next = sea_pkg::STAT_NO_SPACE;
              state_next      = sea_pkg::ST_DONE;
            end else begin
              p_next        = (ptr >= count) ? '0 : ptr;
              ram_req.raddr = (ptr >= count) ? '0 : ptr[IW-1:0];
              state_next    = sea_pkg::ST_ALLOC_RD;
            end
          end else begin
            addr_next = in_addr;
            p_next    = '0;
            if (count == '0) begin
              cur_v_next = 1'b0;
              state_next = sea_pkg::ST_DECIDE;
            end else begin
              ram_req.raddr = '0;
              state_next    = sea_pkg::ST_SEARCH;
            end
          end
        end
      end

      sea_pkg::ST_ALLOC_RD: begin
        res_granted_next = rdata.start;
        ptr_next         = p;
        if (rdata.len > sea_pkg::LEN_W'(1)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = p[IW-1:0];
          ram_req.wdata = '{start: rdata.start + sea_pkg::ADDR_W'(sea_pkg::PAGE_BYTES),
                            len: rdata.len - sea_pkg::LEN_W'(1)};
          state_next    = sea_pkg::ST_DONE;
        end else if ((p + CW'(1)) < count) begin
          ram_req.raddr = IW'(p + CW'(1));
          w_next        = p;
          state_next    = sea_pkg::ST_SHIFT_DN;
        end else begin
          count_next = count - CW'(1);
          state_next = sea_pkg::ST_DONE;
        end
      end

      sea_pkg::ST_SEARCH: begin
        if (rdata.start < addr) begin
          prev_next = rdata;
          p_next    = p + CW'(1);
          if ((p + CW'(1)) < count) begin
            ram_req.raddr = IW'(p + CW'(1));
          end else begin
            cur_v_next = 1'b0;
            state_next = sea_pkg::ST_DECIDE;
          end
        end else begin
          cur_next   = rdata;
          cur_v_next = 1'b1;
          state_next = sea_pkg::ST_DECIDE;
        end
      end

      sea_pkg::ST_DECIDE: begin
        state_next = sea_pkg::ST_DONE;
        if (dup) begin
          res_status_next = sea_pkg::STAT_DOUBLE_FREE;
        end else if (jn && jp) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = IW'(p - CW'(1));
          ram_req.wdata = '{start: prev.start, len: jp_sum[sea_pkg::LEN_W-1:0]};
          if (ptr >= p) begin
            ptr_next = (ptr == p) ? p - CW'(1) : ptr - CW'(1);
          end
          if ((p + CW'(1)) < count) begin
            ram_req.raddr = IW'(p + CW'(1));
            w_next        = p;
            state_next    = sea_pkg::ST_SHIFT_DN;
          end else begin
            count_next = count - CW'(1);
          end
        end else if (jn) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = p[IW-1:0];
          ram_req.wdata = '{start: addr, len: cur.len + sea_pkg::LEN_W'(1)};
        end else if (jp) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = IW'(p - CW'(1));
          ram_req.wdata = '{start: prev.start, len: prev.len + sea_pkg::LEN_W'(1)};
        end else if (count >= CW'(sea_pkg::MAX_EXTENTS)) begin
          res_status_next = sea_pkg::STAT_TABLE_FULL;
        end else if (p < count) begin
          ram_req.raddr = IW'(count - CW'(1));
          w_next        = count;
          state_next    = sea_pkg::ST_SHIFT_UP;
        end else begin
          state_next = sea_pkg::ST_INSERT;
        end
      end

      sea_pkg::ST_SHIFT_DN: begin
        // entry w takes the one above it; read two ahead to keep one move per cycle
        ram_req.we    = 1'b1;
        ram_req.waddr = w[IW-1:0];
        ram_req.wdata = rdata;
        if ((w + CW'(2)) < count) begin
          ram_req.raddr = IW'(w + CW'(2));
          w_next        = w + CW'(1);
        end else begin
          count_next = count - CW'(1);
          state_next = sea_pkg::ST_DONE;
        end
      end

      sea_pkg::ST_SHIFT_UP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = w[IW-1:0];
        ram_req.wdata = rdata;
        if ((w - CW'(1)) > p) begin
          ram_req.raddr = IW'(w - CW'(2));
          w_next        = w - CW'(1);
        end else begin
          state_next = sea_pkg::ST_INSERT;
        end
      end

      sea_pkg::ST_INSERT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = p[IW-1:0];
        ram_req.wdata = '{start: addr, len: sea_pkg::LEN_W'(1)};
        count_next    = count + CW'(1);
        if (ptr >= p) begin
          ptr_next = ptr + CW'(1);
        end
        state_next = sea_pkg::ST_DONE;
      end

      sea_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = sea_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sea_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sea_pkg::ST_IDLE;
      count       <= '0;
      ptr         <= '0;
      reload_pend <= 1'b1;
      swap_base   <= '0;
      total_pages <= sea_pkg::LEN_W'(131072);
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      ptr         <= ptr_next;
      reload_pend <= reload_pend_next;
      if (cfg_fire) begin
        case (cfg_index)
          sea_pkg::CFG_SWAP_BASE:   swap_base   <= cfg_data;
          sea_pkg::CFG_TOTAL_PAGES: total_pages <= cfg_data[sea_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if ((state == sea_pkg::ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p           <= p_next;
    w           <= w_next;
    addr        <= addr_next;
    prev        <= prev_next;
    cur         <= cur_next;
    cur_v       <= cur_v_next;
    res_granted <= res_granted_next;
    res_status  <= res_status_next;
    if ((state == sea_pkg::ST_DONE) && out_free) begin
      m_tdata <= {6'b0, res_status, res_granted};
    end
  end

  `SEA_ASSERT(a_count_bound, count <= CW'(sea_pkg::MAX_EXTENTS), "extent count beyond table")
  `SEA_ASSERT(a_ptr_bound, ptr <= count, "next-fit pointer beyond end of table")
  `SEA_ASSERT(a_result_from_done, $rose(m_tvalid) |-> $past(state == sea_pkg::ST_DONE), "result without completion")
  `SEA_ASSERT(a_idle_write_reload, (state == sea_pkg::ST_IDLE && ram_req.we) |-> reload_pend, "table write while idle")

endmodule

// ===== src/swap_extent_allocator.sv =====
// Next-fit swap page allocator. A free-extent table (start, page count), kept sorted by
// address, lives in a single-port-write, registered-read RAM of sea_pkg::MAX_EXTENTS entries.
// An allocate reads the extent at the next-fit pointer and takes its first page; when the
// emptied extent at index i leaves n entries above it, they move down. A free walks the
// table one entry per cycle up to its insertion point p, then decides, then moves entries
// one per cycle if a new extent is inserted or two extents merge.
// The result stage then waits for the downstream transfer; one request is handled at a time.
// After reset and after each register write the table reloads, and no request is taken
// while the reload is pending.
module swap_extent_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // page_address
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // granted_address[31:0], status[33:32], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  sea_pkg::ram_req_t ram_req;
  sea_pkg::extent_t  rdata;

  sea_extent_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  sea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_req   (ram_req),
    .rdata     (rdata)
  );

endmodule
